@@ sv/slca_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and register codes of the line segment coverage unit.
// No dependencies; every other file of the block imports this package.
package slca_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int DOT_W    = PROD_W + 1;
   localparam int REM_W    = DOT_W - 1;
   localparam int H_FRAC   = 48;
   localparam int H_W      = H_FRAC + 1;
   localparam int H_LO_W   = H_FRAC / 2;
   localparam int H_HI_W   = H_W - H_LO_W;
   localparam int MHI_W    = DIFF_W + H_HI_W;
   localparam int MLO_W    = DIFF_W + H_LO_W;
   localparam int PROJ_W   = DIFF_W + 1;
   localparam int SCALED_W = DIFF_W + H_W + 1;
   localparam int OFS_W    = DIFF_W + 2;
   localparam int SQ_W     = 2 * OFS_W;
   localparam int RAD_W    = SQ_W + 1;
   localparam int ROOT_W   = (RAD_W + 1) / 2;
   localparam int TRIAL_W  = RAD_W + 2;
   localparam int REG_W    = 31;
   localparam int DIST_W   = ROOT_W + 1;
   localparam int ALPHA_W  = 17;
   localparam int QUO_W    = ALPHA_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(65536);
   localparam logic [ALPHA_W:0]   ALPHA_EDGE   = (ALPHA_W + 1)'(81920);
   localparam logic [ALPHA_W:0]   ALPHA_MARGIN = ALPHA_EDGE - {1'b0, ALPHA_ONE};

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic [REM_W-1:0]              rem_type;
   typedef logic [H_FRAC-1:0]             hq_type;
   typedef logic [H_W-1:0]                h_type;
   typedef logic [DIFF_W-1:0]             mag_type;
   typedef logic [MHI_W-1:0]              mhi_type;
   typedef logic [MLO_W-1:0]              mlo_type;
   typedef logic [PROJ_W-1:0]             proj_type;
   typedef logic [SCALED_W-1:0]           scaled_type;
   typedef logic signed [OFS_W-1:0]       ofs_type;
   typedef logic [OFS_W-1:0]              omag_type;
   typedef logic [SQ_W-1:0]               sq_type;
   typedef logic [RAD_W-1:0]              rad_type;
   typedef logic [ROOT_W-1:0]             root_type;
   typedef logic [TRIAL_W-1:0]            trial_type;
   typedef logic [REG_W-1:0]              cfg_type;
   typedef logic signed [DIST_W-1:0]      dist_type;
   typedef logic [REG_W:0]                drem_type;
   typedef logic [QUO_W-1:0]              quo_type;
   typedef logic [ALPHA_W-1:0]            alpha_type;
   typedef logic [CSR_DATA_W-1:0]         csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_HALF_WIDTH = 1'b0,
      CSR_WORLD_UPP       = 1'b1
   } csr_idx_type;

endpackage

@@ sv/slca_req_if.sv @@
`timescale 1ns / 1ps
// Input channel: one sample point and one segment per transfer.
// Depends on slca_pkg.
interface slca_req_if;
   import slca_pkg::*;
   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   modport source (output valid, pixel_x, pixel_y, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, start_x, start_y, end_x, end_y,
                   output ready);
endinterface

@@ sv/slca_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel: one coverage value per transfer.
// Depends on slca_pkg.
interface slca_rsp_if;
   import slca_pkg::*;
   logic      valid;
   logic      ready;
   alpha_type coverage_alpha;
   modport source (output valid, coverage_alpha, input ready);
   modport sink   (input valid, coverage_alpha, output ready);
endinterface

@@ sv/slca_csr_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on slca_pkg.
interface slca_csr_if;
   import slca_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/segment_line_coverage_alpha_unit.sv @@
`timescale 1ns / 1ps
// Anti-aliased coverage of a thick line segment at one sample point per item.
// Depends on slca_pkg, the three channel interfaces and slca_sqrt_pipe.
//
// Usage: each transfer on req_ch carries a sample point and the two endpoints
// of a segment, all signed Q16.16. Each item yields exactly one transfer on
// rsp_ch carrying coverage_alpha in unsigned Q1.16. csr_ch writes the half
// line width (index 0) and the world units per pixel (index 1); it is always
// ready and should only be used while no item is in flight.
//
// The pipeline consists of a restoring divider for the projection parameter, a
// 36-stage square root and a divider for the pixel distance, plus the multiply
// and add stages in between. One item enters per cycle while rsp_ch is not
// stalled, so throughput is then one item per clock.
//
// Reset clears every valid bit and loads the registers with a half width of
// zero and one pixel per world unit. When the receiver holds rsp_ch.ready low
// with a result waiting, the whole pipeline freezes and req_ch.ready drops in
// the same cycle; nothing is lost or repeated, and the flow resumes as soon as
// the result is taken. Bubbles in the pipeline do not block new transfers.
module segment_line_coverage_alpha_unit (
   input  logic       clock,
   input  logic       reset,
   slca_req_if.sink   req_ch,
   slca_rsp_if.source rsp_ch,
   slca_csr_if.sink   csr_ch
);
   import slca_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers. A pixel size of zero is used as one LSB.
   // ---------------------------------------------------------------------
   cfg_type lhw_ff;
   cfg_type upp_ff;
   cfg_type upp_eff;

   assign csr_ch.ready = 1'b1;
   assign upp_eff = (upp_ff == '0) ? cfg_type'(1) : upp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lhw_ff <= '0;
         upp_ff <= cfg_type'(1) << FRAC_BITS;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_LINE_HALF_WIDTH: lhw_ff <= csr_ch.data[REG_W-1:0];
            CSR_WORLD_UPP:       upp_ff <= csr_ch.data[REG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Global advance: the pipeline moves whenever the output register is
   // empty or its result is being transferred this cycle.
   // ---------------------------------------------------------------------
   logic out_v_ff;
   logic adv;

   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: differences D = P - A and E = B - A.
   logic     s1_v_ff;
   diff_type s1_dx_ff, s1_dy_ff, s1_ex_ff, s1_ey_ff;

   // Stage 2: the four products of the dot product and the squared length.
   logic     s2_v_ff;
   prod_type s2_pdx_ff, s2_pdy_ff, s2_pex_ff, s2_pey_ff;
   diff_type s2_dx_ff, s2_dy_ff, s2_ex_ff, s2_ey_ff;

   // Stage 3: dot = D.E and len2 = E.E.
   logic     s3_v_ff;
   dot_type  s3_dot_ff, s3_len_ff;
   diff_type s3_dx_ff, s3_dy_ff, s3_ex_ff, s3_ey_ff;

   // Divider for the projection parameter: entry 0 is the setup stage,
   // entries 1..H_FRAC each produce one quotient bit.
   logic     dv_v_ff    [H_FRAC+1];
   rem_type  dv_r_ff    [H_FRAC+1];
   rem_type  dv_len_ff  [H_FRAC+1];
   hq_type   dv_q_ff    [H_FRAC+1];
   logic     dv_zero_ff [H_FRAC+1];
   logic     dv_full_ff [H_FRAC+1];
   diff_type dv_dx_ff   [H_FRAC+1];
   diff_type dv_dy_ff   [H_FRAC+1];
   diff_type dv_ex_ff   [H_FRAC+1];
   diff_type dv_ey_ff   [H_FRAC+1];
   rem_type  dv_r_in    [H_FRAC+1];
   hq_type   dv_q_in    [H_FRAC+1];

   always_comb begin
      rem_type cand;
      logic    ge;
      // The setup stage only keeps a remainder when 0 < dot < len2.
      dv_r_in[0] = (s3_dot_ff <= 0 || s3_dot_ff >= s3_len_ff) ? '0 : s3_dot_ff[REM_W-1:0];
      dv_q_in[0] = '0;
      for (int k = 1; k <= H_FRAC; k++) begin
         cand       = {dv_r_ff[k-1][REM_W-2:0], 1'b0};
         ge         = cand >= dv_len_ff[k-1];
         dv_r_in[k] = ge ? cand - dv_len_ff[k-1] : cand;
         dv_q_in[k] = {dv_q_ff[k-1][H_FRAC-2:0], ge};
      end
   end

   // Stage M: the parameter h times |Ex| and |Ey|, split into two partial
   // products per axis to keep each multiplier near 32 bits.
   h_type    h_m;
   mag_type  mx_m, my_m;
   logic     m_v_ff;
   mhi_type  m_hx_ff, m_hy_ff;
   mlo_type  m_lx_ff, m_ly_ff;
   logic     m_xneg_ff, m_yneg_ff;
   diff_type m_dx_ff, m_dy_ff;

   always_comb begin
      if (dv_zero_ff[H_FRAC]) begin
         h_m = '0;
      end else if (dv_full_ff[H_FRAC]) begin
         h_m = h_type'(1) << H_FRAC;
      end else begin
         h_m = {1'b0, dv_q_ff[H_FRAC]};
      end
      mx_m = dv_ex_ff[H_FRAC][DIFF_W-1] ? mag_type'(-dv_ex_ff[H_FRAC])
                                         : mag_type'(dv_ex_ff[H_FRAC]);
      my_m = dv_ey_ff[H_FRAC][DIFF_W-1] ? mag_type'(-dv_ey_ff[H_FRAC])
                                         : mag_type'(dv_ey_ff[H_FRAC]);
   end

   // Stage P: recombine, round half away from zero and drop the fraction.
   logic       p_v_ff;
   proj_type   p_px_ff, p_py_ff;
   logic       p_xneg_ff, p_yneg_ff;
   diff_type   p_dx_ff, p_dy_ff;
   scaled_type sc_x, sc_y;

   assign sc_x = (scaled_type'(m_hx_ff) << H_LO_W) + scaled_type'(m_lx_ff)
               + (scaled_type'(1) << (H_FRAC - 1));
   assign sc_y = (scaled_type'(m_hy_ff) << H_LO_W) + scaled_type'(m_ly_ff)
               + (scaled_type'(1) << (H_FRAC - 1));

   // Stage O: offset from the closest point, kept as a magnitude.
   logic     o_v_ff;
   omag_type o_mx_ff, o_my_ff;
   ofs_type  ox_o, oy_o;

   assign ox_o = p_xneg_ff ? ofs_type'(p_dx_ff) + ofs_type'(p_px_ff)
                           : ofs_type'(p_dx_ff) - ofs_type'(p_px_ff);
   assign oy_o = p_yneg_ff ? ofs_type'(p_dy_ff) + ofs_type'(p_py_ff)
                           : ofs_type'(p_dy_ff) - ofs_type'(p_py_ff);

   // Stage Q: squares; stage V: their sum feeds the square root.
   logic    q_v_ff;
   sq_type  q_sx_ff, q_sy_ff;
   logic    v_v_ff;
   rad_type v_rad_ff;

   logic     sq_v_ff [ROOT_W];
   root_type root_w;

   slca_sqrt_pipe u_sqrt (
      .clock  (clock),
      .adv    (adv),
      .rad_i  (v_rad_ff),
      .root_o (root_w)
   );

   // Pixel distance divider: entry 0 classifies s = dist - half width,
   // entries 1..QUO_W each produce one quotient bit of s * 2^16 / upp.
   dist_type s_w;
   logic     s_full_w, s_zero_w;
   drem_type upp_ext;

   assign s_w      = dist_type'(root_w) - dist_type'(lhw_ff);
   assign s_full_w = s_w[DIST_W-1] || (s_w == '0);
   assign s_zero_w = !s_full_w && (s_w >= dist_type'({upp_eff, 1'b0}));
   assign upp_ext  = {1'b0, upp_eff};

   logic     qd_v_ff    [QUO_W+1];
   drem_type qd_r_ff    [QUO_W+1];
   quo_type  qd_q_ff    [QUO_W+1];
   logic     qd_full_ff [QUO_W+1];
   logic     qd_zero_ff [QUO_W+1];
   drem_type qd_r_in    [QUO_W+1];
   quo_type  qd_q_in    [QUO_W+1];

   always_comb begin
      drem_type cand;
      logic     ge;
      qd_r_in[0] = (s_full_w || s_zero_w) ? '0 : s_w[REG_W:0];
      qd_q_in[0] = '0;
      for (int k = 1; k <= QUO_W; k++) begin
         // The first step compares s itself, which is already below 2 * upp.
         cand       = (k == 1) ? qd_r_ff[k-1] : {qd_r_ff[k-1][REG_W-1:0], 1'b0};
         ge         = cand >= upp_ext;
         qd_r_in[k] = ge ? cand - upp_ext : cand;
         qd_q_in[k] = {qd_q_ff[k-1][QUO_W-2:0], ge};
      end
   end

   // Final stage: alpha = 1.25 - t, clamped to the range 0..1.
   logic [ALPHA_W:0] t_ext;
   logic [ALPHA_W:0] a_diff;
   alpha_type        alpha_in;
   alpha_type        alpha_ff;

   assign t_ext  = {1'b0, qd_q_ff[QUO_W]};
   assign a_diff = ALPHA_EDGE - t_ext;

   always_comb begin
      if (qd_full_ff[QUO_W]) begin
         alpha_in = ALPHA_ONE;
      end else if (qd_zero_ff[QUO_W]) begin
         alpha_in = '0;
      end else if (t_ext <= ALPHA_MARGIN) begin
         alpha_in = ALPHA_ONE;
      end else if (t_ext >= ALPHA_EDGE) begin
         alpha_in = '0;
      end else begin
         alpha_in = a_diff[ALPHA_W-1:0];
      end
   end

   assign rsp_ch.valid          = out_v_ff;
   assign rsp_ch.coverage_alpha = alpha_ff;

   // ---------------------------------------------------------------------
   // Valid bits: cleared by reset, shifted on every advance.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         m_v_ff   <= 1'b0;
         p_v_ff   <= 1'b0;
         o_v_ff   <= 1'b0;
         q_v_ff   <= 1'b0;
         v_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= H_FRAC; k++) dv_v_ff[k] <= 1'b0;
         for (int k = 0; k < ROOT_W; k++)  sq_v_ff[k] <= 1'b0;
         for (int k = 0; k <= QUO_W; k++)  qd_v_ff[k] <= 1'b0;
      end else if (adv) begin
         s1_v_ff    <= req_ch.valid;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         dv_v_ff[0] <= s3_v_ff;
         for (int k = 1; k <= H_FRAC; k++) dv_v_ff[k] <= dv_v_ff[k-1];
         m_v_ff     <= dv_v_ff[H_FRAC];
         p_v_ff     <= m_v_ff;
         o_v_ff     <= p_v_ff;
         q_v_ff     <= o_v_ff;
         v_v_ff     <= q_v_ff;
         sq_v_ff[0] <= v_v_ff;
         for (int k = 1; k < ROOT_W; k++) sq_v_ff[k] <= sq_v_ff[k-1];
         qd_v_ff[0] <= sq_v_ff[ROOT_W-1];
         for (int k = 1; k <= QUO_W; k++) qd_v_ff[k] <= qd_v_ff[k-1];
         out_v_ff   <= qd_v_ff[QUO_W];
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers: no reset, they move with the valid bits.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dx_ff <= diff_type'(req_ch.pixel_x) - diff_type'(req_ch.start_x);
         s1_dy_ff <= diff_type'(req_ch.pixel_y) - diff_type'(req_ch.start_y);
         s1_ex_ff <= diff_type'(req_ch.end_x) - diff_type'(req_ch.start_x);
         s1_ey_ff <= diff_type'(req_ch.end_y) - diff_type'(req_ch.start_y);

         s2_pdx_ff <= s1_dx_ff * s1_ex_ff;
         s2_pdy_ff <= s1_dy_ff * s1_ey_ff;
         s2_pex_ff <= s1_ex_ff * s1_ex_ff;
         s2_pey_ff <= s1_ey_ff * s1_ey_ff;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_ex_ff  <= s1_ex_ff;
         s2_ey_ff  <= s1_ey_ff;

         s3_dot_ff <= dot_type'(s2_pdx_ff) + dot_type'(s2_pdy_ff);
         s3_len_ff <= dot_type'(s2_pex_ff) + dot_type'(s2_pey_ff);
         s3_dx_ff  <= s2_dx_ff;
         s3_dy_ff  <= s2_dy_ff;
         s3_ex_ff  <= s2_ex_ff;
         s3_ey_ff  <= s2_ey_ff;

         dv_len_ff[0]  <= s3_len_ff[REM_W-1:0];
         dv_zero_ff[0] <= s3_dot_ff <= 0;
         dv_full_ff[0] <= (s3_dot_ff > 0) && (s3_dot_ff >= s3_len_ff);
         dv_dx_ff[0]   <= s3_dx_ff;
         dv_dy_ff[0]   <= s3_dy_ff;
         dv_ex_ff[0]   <= s3_ex_ff;
         dv_ey_ff[0]   <= s3_ey_ff;
         for (int k = 0; k <= H_FRAC; k++) begin
            dv_r_ff[k] <= dv_r_in[k];
            dv_q_ff[k] <= dv_q_in[k];
         end
         for (int k = 1; k <= H_FRAC; k++) begin
            dv_len_ff[k]  <= dv_len_ff[k-1];
            dv_zero_ff[k] <= dv_zero_ff[k-1];
            dv_full_ff[k] <= dv_full_ff[k-1];
            dv_dx_ff[k]   <= dv_dx_ff[k-1];
            dv_dy_ff[k]   <= dv_dy_ff[k-1];
            dv_ex_ff[k]   <= dv_ex_ff[k-1];
            dv_ey_ff[k]   <= dv_ey_ff[k-1];
         end

         m_hx_ff   <= mx_m * h_m[H_W-1:H_LO_W];
         m_lx_ff   <= mx_m * h_m[H_LO_W-1:0];
         m_hy_ff   <= my_m * h_m[H_W-1:H_LO_W];
         m_ly_ff   <= my_m * h_m[H_LO_W-1:0];
         m_xneg_ff <= dv_ex_ff[H_FRAC][DIFF_W-1];
         m_yneg_ff <= dv_ey_ff[H_FRAC][DIFF_W-1];
         m_dx_ff   <= dv_dx_ff[H_FRAC];
         m_dy_ff   <= dv_dy_ff[H_FRAC];

         p_px_ff   <= sc_x[H_FRAC +: PROJ_W];
         p_py_ff   <= sc_y[H_FRAC +: PROJ_W];
         p_xneg_ff <= m_xneg_ff;
         p_yneg_ff <= m_yneg_ff;
         p_dx_ff   <= m_dx_ff;
         p_dy_ff   <= m_dy_ff;

         o_mx_ff <= ox_o[OFS_W-1] ? omag_type'(-ox_o) : omag_type'(ox_o);
         o_my_ff <= oy_o[OFS_W-1] ? omag_type'(-oy_o) : omag_type'(oy_o);

         q_sx_ff <= o_mx_ff * o_mx_ff;
         q_sy_ff <= o_my_ff * o_my_ff;

         v_rad_ff <= rad_type'(q_sx_ff) + rad_type'(q_sy_ff);

         qd_full_ff[0] <= s_full_w;
         qd_zero_ff[0] <= s_zero_w;
         for (int k = 0; k <= QUO_W; k++) begin
            qd_r_ff[k] <= qd_r_in[k];
            qd_q_ff[k] <= qd_q_in[k];
         end
         for (int k = 1; k <= QUO_W; k++) begin
            qd_full_ff[k] <= qd_full_ff[k-1];
            qd_zero_ff[k] <= qd_zero_ff[k-1];
         end

         alpha_ff <= alpha_in;
      end
   end

endmodule

@@ sv/slca_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on slca_pkg; stalls on the shared advance enable of the top level.
module slca_sqrt_pipe (
   input  logic              clock,
   input  logic              adv,
   input  slca_pkg::rad_type rad_i,
   output slca_pkg::root_type root_o
);
   import slca_pkg::*;

   rad_type  rem_ff  [ROOT_W];
   root_type root_ff [ROOT_W];
   rad_type  rem_in  [ROOT_W];
   root_type root_in [ROOT_W];

   // Stage k settles bit (ROOT_W-1-k). The remainder holds rad - root^2, so a
   // candidate bit b is kept when the remainder covers 2*root*2^b + 4^b.
   always_comb begin
      rad_type   rem_p;
      root_type  root_p;
      trial_type trial;
      logic      ge;
      int        b;
      for (int k = 0; k < ROOT_W; k++) begin
         b      = ROOT_W - 1 - k;
         rem_p  = (k == 0) ? rad_i : rem_ff[(k == 0) ? 0 : k - 1];
         root_p = (k == 0) ? '0 : root_ff[(k == 0) ? 0 : k - 1];
         trial  = (trial_type'(root_p) << (b + 1)) + (trial_type'(1) << (2 * b));
         ge     = trial_type'(rem_p) >= trial;
         rem_in[k]  = ge ? rem_p - trial[RAD_W-1:0] : rem_p;
         root_in[k] = ge ? (root_p | (root_type'(1) << b)) : root_p;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root_o = root_ff[ROOT_W-1];

endmodule

@@ sv/slca_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the line segment coverage unit, bound to the top level.
// Depends on slca_pkg and segment_line_coverage_alpha_unit.
module slca_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input slca_pkg::alpha_type rsp_alpha,
   input logic                csr_valid,
   input logic                csr_ready
);
   import slca_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha <= ALPHA_ONE)
      else $error("coverage above full");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alpha))
      else $error("stalled result changed");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the output stall");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind segment_line_coverage_alpha_unit slca_checker u_slca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_alpha (rsp_ch.coverage_alpha),
   .csr_valid (csr_ch.valid),
   .csr_ready (csr_ch.ready)
);
